@@ hdl/polygon_sat_contact_defines.svh @@
// ----------------------------------------------------------------------------
// polygon_sat_contact assertion macros
// Shared property shapes for the stream checkers of the contact block.
// ----------------------------------------------------------------------------
`ifndef POLYGON_SAT_CONTACT_DEFINES_SVH
`define POLYGON_SAT_CONTACT_DEFINES_SVH

// A stalled item keeps its payload until it is taken.
`define PSC_ASSERT_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error("item changed while stalled");

// Generic same-cycle implication.
`define PSC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error("implication failed");

`endif

@@ hdl/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// Types and constants shared by the polygon contact front end, queue and engine.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

  localparam int MAX_VERTS   = 16;
  localparam int IDX_W       = $clog2(MAX_VERTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int COORD_W     = 32;
  localparam int NORM_W      = 18;
  localparam int DEPTH_W     = 31;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 200;

  typedef enum logic [1:0] {
    KIND_A,
    KIND_A_LAST,
    KIND_B,
    KIND_B_TEST
  } psc_kind_e;

  typedef struct packed {
    psc_kind_e                  kind;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  x;
  } psc_entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EDGE_RD0,
    ST_EDGE_RD1,
    ST_EDGE_VEC,
    ST_NORM,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_NORM_SIGN,
    ST_PRJ_RD,
    ST_PRJ_MX,
    ST_PRJ_MY,
    ST_PRJ_CMP,
    ST_EDGE_END,
    ST_PASS_END,
    ST_FIN_DEP,
    ST_FIN_OX,
    ST_FIN_OY,
    ST_FIN_PT,
    ST_EMIT
  } psc_state_e;

endpackage

`default_nettype wire

@@ hdl/polygon_sat_contact.sv @@
// ----------------------------------------------------------------------------
// polygon_sat_contact
// Two-way separating-axis contact test between two convex polygons.
// ----------------------------------------------------------------------------
// Slave stream: one vertex per item, tuser selects polygon A (0) or B (1),
// tlast marks a polygon's last vertex. The last vertex of B starts a test and
// produces exactly one result item on the master stream; tuser of the result
// is the colliding flag, tdata carries depth, normal and contact points (all
// zero when there is no contact). Up to 16 vertices per polygon are kept.
// Each edge of nonzero length is normalized by shifting and then runs a
// 31-step square root and an 18-step divider; each vertex projection
// passes through read, x-product, y-product and compare states, using the
// single read port of each vertex store. The test after polygon A is found
// to be separated ends after the A edges. While a test runs, new vertices
// wait in a four-item queue; one result can wait in the output register
// while the next items are taken. A stalled master holds its result and
// the engine waits only when a second result is ready. Reset empties both
// polygons and drops any queued items and pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_sat_contact import psc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // vertex_x, vertex_y
  input  wire logic                   s_axis_tuser,  // func
  input  wire logic                   s_axis_tlast,  // last_vertex
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // depth, normal_x, normal_y,
                                                     // start_x, start_y, end_x, end_y
  output logic                        m_axis_tuser   // colliding
);

  logic       push_valid, push_ready, pop_valid, pop_ready;
  psc_entry_t push_entry, pop_entry;

  psc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  psc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_entry_i(push_entry),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_entry_o (pop_entry),
    .pop_ready_i (pop_ready)
  );

  psc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (pop_valid),
    .q_entry_i    (pop_entry),
    .q_ready_o    (pop_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ hdl/psc_front.sv @@
// ----------------------------------------------------------------------------
// psc_front
// Input register stage: accepts vertex items and classifies them for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_front import psc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,  // vertex_x, vertex_y
  input  wire logic                  s_axis_tuser,  // func
  input  wire logic                  s_axis_tlast,  // last_vertex
  output logic                       push_valid_o,
  output psc_entry_t                 push_entry_o,
  input  wire logic                  push_ready_i
);

  logic       full_q, full_d;
  psc_entry_t entry_q, entry_d;
  psc_kind_e  kind;

  always_comb begin
    case ({s_axis_tuser, s_axis_tlast})
      2'b00:   kind = KIND_A;
      2'b01:   kind = KIND_A_LAST;
      2'b10:   kind = KIND_B;
      default: kind = KIND_B_TEST;
    endcase
  end

  assign s_axis_tready = !full_q || push_ready_i;
  assign push_valid_o  = full_q;
  assign push_entry_o  = entry_q;

  always_comb begin
    full_d  = full_q;
    entry_d = entry_q;
    if (full_q && push_ready_i) begin
      full_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      full_d        = 1'b1;
      entry_d.kind  = kind;
      entry_d.x     = s_axis_tdata[COORD_W-1:0];
      entry_d.y     = s_axis_tdata[2*COORD_W-1:COORD_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

@@ hdl/psc_queue.sv @@
// ----------------------------------------------------------------------------
// psc_queue
// Small FIFO of classified items between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_queue import psc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_valid_i,
  input  psc_entry_t       push_entry_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output psc_entry_t       pop_entry_o,
  input  wire logic        pop_ready_i
);

  psc_entry_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]       fill_q, fill_d;
  logic                  do_push, do_pop;

  assign push_ready_o = fill_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign pop_entry_o  = slot_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d   = do_push ? wr_q + 1'b1 : wr_q;
    rd_d   = do_pop ? rd_q + 1'b1 : rd_q;
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/psc_engine.sv @@
// ----------------------------------------------------------------------------
// psc_engine
// Vertex store and separating-axis sequencer with output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_engine import psc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_valid_i,
  input  psc_entry_t                  q_entry_i,
  output logic                        q_ready_o,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // depth, normal_x, normal_y,
                                                     // start_x, start_y, end_x, end_y
  output logic                        m_axis_tuser   // colliding
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTS);

  // vertex stores, x in the low half
  logic [2*COORD_W-1:0] verts_a_q [MAX_VERTS];
  logic [2*COORD_W-1:0] verts_b_q [MAX_VERTS];
  logic [2*COORD_W-1:0] rd_a_q, rd_b_q;
  logic [IDX_W-1:0]     raddr_a, raddr_b, waddr;
  logic                 we_a, we_b;

  psc_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic              closed_a_q, closed_a_d, closed_b_q, closed_b_d;
  logic              pass_q, pass_d;
  logic [CNT_W-1:0]  ei_q, ei_d, vj_q, vj_d;
  logic [4:0]        dcnt_q, dcnt_d;
  logic              got_q, got_d, have_q, have_d;
  logic              out_valid_q, out_valid_d;

  logic signed [31:0] pix_q, pix_d, piy_q, piy_d;
  logic [32:0]        mx_q, mx_d, my_q, my_d;
  logic               nsx_q, nsx_d, nsy_q, nsy_d;
  logic [60:0]        sv_q, sv_d, sbit_q, sbit_d;
  logic [59:0]        sq_q, sq_d, prod_q, prod_d;
  logic [61:0]        sr_q, sr_d;
  logic [47:0]        rx_q, rx_d, ry_q, ry_d, dv_q, dv_d;
  logic [17:0]        qx_q, qx_d, qy_q, qy_d;
  logic signed [17:0] nx_q, nx_d, ny_q, ny_d;
  logic signed [31:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [50:0] pxp_q, pxp_d, pyp_q, pyp_d;
  logic signed [51:0] mn_q, mn_d, sep_q, sep_d, sa_q, sa_d;
  logic signed [31:0] bvx_q, bvx_d, bvy_q, bvy_d;
  logic signed [17:0] snx_q, snx_d, sny_q, sny_d, a_nx_q, a_nx_d, a_ny_q, a_ny_d;
  logic signed [31:0] spx_q, spx_d, spy_q, spy_d, apx_q, apx_d, apy_q, apy_d;
  logic               win_q, win_d;
  logic [30:0]        dep_q, dep_d;
  logic signed [17:0] fnx_q, fnx_d, fny_q, fny_d;
  logic signed [33:0] ox_q, ox_d, oy_q, oy_d;
  logic               res_coll_q, res_coll_d;
  logic signed [31:0] rsx_q, rsx_d, rsy_q, rsy_d, rex_q, rex_d, rey_q, rey_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic               out_user_q, out_user_d;

  // combinational helpers
  logic [CNT_W-1:0]    np, nq, ei_n, vj_n, ca, cb;
  logic [IDX_W-1:0]    kidx;
  logic signed [31:0]  p_x, p_y, q_x, q_y;
  logic signed [32:0]  ex, ey, dxv, dyv;
  logic [32:0]         mm;
  logic [61:0]         tr;
  logic signed [51:0]  pr, dneg;
  logic [35:0]         dd;
  logic signed [49:0]  mprod;
  logic signed [49:0]  mrnd;
  logic signed [31:0]  base_x, base_y;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign np   = pass_q ? cnt_b_q : cnt_a_q;
  assign nq   = pass_q ? cnt_a_q : cnt_b_q;
  assign ei_n = ei_q + 1'b1;
  assign vj_n = vj_q + 1'b1;
  assign kidx = (ei_n < np) ? ei_n[IDX_W-1:0] : '0;

  assign p_x = pass_q ? rd_b_q[31:0]  : rd_a_q[31:0];
  assign p_y = pass_q ? rd_b_q[63:32] : rd_a_q[63:32];
  assign q_x = pass_q ? rd_a_q[31:0]  : rd_b_q[31:0];
  assign q_y = pass_q ? rd_a_q[63:32] : rd_b_q[63:32];

  always_comb begin
    logic [IDX_W-1:0] pidx;
    pidx    = (state_q == ST_EDGE_RD1) ? kidx : ei_q[IDX_W-1:0];
    raddr_a = pass_q ? vj_q[IDX_W-1:0] : pidx;
    raddr_b = pass_q ? pidx : vj_q[IDX_W-1:0];
  end

  assign q_ready_o     = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  always_comb begin
    state_d = state_q;
    cnt_a_d = cnt_a_q;     cnt_b_d = cnt_b_q;
    closed_a_d = closed_a_q; closed_b_d = closed_b_q;
    pass_d = pass_q;  ei_d = ei_q;  vj_d = vj_q;  dcnt_d = dcnt_q;
    got_d = got_q;    have_d = have_q;
    out_valid_d = out_valid_q;
    pix_d = pix_q; piy_d = piy_q; mx_d = mx_q; my_d = my_q;
    nsx_d = nsx_q; nsy_d = nsy_q; sq_d = sq_q; prod_d = prod_q;
    sv_d = sv_q; sr_d = sr_q; sbit_d = sbit_q;
    rx_d = rx_q; ry_d = ry_q; dv_d = dv_q; qx_d = qx_q; qy_d = qy_q;
    nx_d = nx_q; ny_d = ny_q; cx_d = cx_q; cy_d = cy_q;
    pxp_d = pxp_q; pyp_d = pyp_q; mn_d = mn_q; bvx_d = bvx_q; bvy_d = bvy_q;
    sep_d = sep_q; snx_d = snx_q; sny_d = sny_q; spx_d = spx_q; spy_d = spy_q;
    sa_d = sa_q; a_nx_d = a_nx_q; a_ny_d = a_ny_q; apx_d = apx_q; apy_d = apy_q;
    win_d = win_q; dep_d = dep_q; fnx_d = fnx_q; fny_d = fny_q;
    ox_d = ox_q; oy_d = oy_q;
    res_coll_d = res_coll_q;
    rsx_d = rsx_q; rsy_d = rsy_q; rex_d = rex_q; rey_d = rey_q;
    out_data_d = out_data_q; out_user_d = out_user_q;
    we_a = 1'b0; we_b = 1'b0; waddr = '0;
    ca = '0; cb = '0;
    ex = '0; ey = '0; dxv = '0; dyv = '0; mm = '0; tr = '0; pr = '0;
    dneg = '0; dd = '0; mprod = '0; mrnd = '0; base_x = '0; base_y = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_entry_i.kind == KIND_A || q_entry_i.kind == KIND_A_LAST) begin
            ca = closed_a_q ? '0 : cnt_a_q;
            if (ca < CNT_MAX) begin
              we_a  = 1'b1;
              waddr = ca[IDX_W-1:0];
              ca    = ca + 1'b1;
            end
            cnt_a_d    = ca;
            closed_a_d = q_entry_i.kind == KIND_A_LAST;
          end else begin
            cb = closed_b_q ? '0 : cnt_b_q;
            if (cb < CNT_MAX) begin
              we_b  = 1'b1;
              waddr = cb[IDX_W-1:0];
              cb    = cb + 1'b1;
            end
            cnt_b_d    = cb;
            closed_b_d = 1'b0;
            if (q_entry_i.kind == KIND_B_TEST) begin
              closed_a_d = 1'b1;
              closed_b_d = 1'b1;
              res_coll_d = 1'b0;
              pass_d     = 1'b0;
              ei_d       = '0;
              have_d     = 1'b0;
              state_d    = (cnt_a_q == '0) ? ST_EMIT : ST_EDGE_RD0;
            end
          end
        end
      end
      ST_EDGE_RD0: state_d = ST_EDGE_RD1;
      ST_EDGE_RD1: begin
        pix_d   = p_x;
        piy_d   = p_y;
        state_d = ST_EDGE_VEC;
      end
      ST_EDGE_VEC: begin
        // normal direction is (-ey, ex)
        ex    = {p_x[31], p_x} - {pix_q[31], pix_q};
        ey    = {p_y[31], p_y} - {piy_q[31], piy_q};
        dxv   = -ey;
        dyv   = ex;
        nsx_d = dxv[32];
        nsy_d = dyv[32];
        mx_d  = dxv[32] ? 33'(-dxv) : 33'(dxv);
        my_d  = dyv[32] ? 33'(-dyv) : 33'(dyv);
        vj_d  = '0;
        got_d = 1'b0;
        if (ex == '0 && ey == '0) begin
          nx_d    = '0;
          ny_d    = '0;
          state_d = ST_PRJ_RD;
        end else begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        // bring the larger magnitude into [2^29, 2^30)
        mm = (mx_q > my_q) ? mx_q : my_q;
        if (mm[32:30] != '0) begin
          mx_d = mx_q >> 1;
          my_d = my_q >> 1;
        end else if (!mm[29]) begin
          mx_d = mx_q << 1;
          my_d = my_q << 1;
        end else begin
          state_d = ST_SQX;
        end
      end
      ST_SQX: begin
        sq_d    = mx_q[29:0] * mx_q[29:0];
        state_d = ST_SQY;
      end
      ST_SQY: begin
        prod_d  = my_q[29:0] * my_q[29:0];
        state_d = ST_SUM;
      end
      ST_SUM: begin
        sv_d    = {1'b0, sq_q} + {1'b0, prod_q};
        sr_d    = '0;
        sbit_d  = 61'd1 << 60;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        tr = sr_q + {1'b0, sbit_q};
        if ({1'b0, sv_q} >= tr) begin
          sv_d = sv_q - tr[60:0];
          sr_d = (sr_q >> 1) + {1'b0, sbit_q};
        end else begin
          sr_d = sr_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        if (sbit_q[0]) begin
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        rx_d    = {2'b0, mx_q[29:0], 16'b0} + {18'b0, sr_q[30:1]};
        ry_d    = {2'b0, my_q[29:0], 16'b0} + {18'b0, sr_q[30:1]};
        dv_d    = {sr_q[30:0], 17'b0};
        qx_d    = '0;
        qy_d    = '0;
        dcnt_d  = 5'd17;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (rx_q >= dv_q) begin
          rx_d = rx_q - dv_q;
        end
        if (ry_q >= dv_q) begin
          ry_d = ry_q - dv_q;
        end
        qx_d   = {qx_q[16:0], rx_q >= dv_q};
        qy_d   = {qy_q[16:0], ry_q >= dv_q};
        dv_d   = dv_q >> 1;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == '0) begin
          state_d = ST_NORM_SIGN;
        end
      end
      ST_NORM_SIGN: begin
        nx_d    = nsx_q ? -$signed(qx_q) : $signed(qx_q);
        ny_d    = nsy_q ? -$signed(qy_q) : $signed(qy_q);
        state_d = ST_PRJ_RD;
      end
      ST_PRJ_RD: state_d = ST_PRJ_MX;
      ST_PRJ_MX: begin
        cx_d    = q_x;
        cy_d    = q_y;
        dxv     = {q_x[31], q_x} - {pix_q[31], pix_q};
        pxp_d   = dxv * nx_q;
        state_d = ST_PRJ_MY;
      end
      ST_PRJ_MY: begin
        dyv     = {cy_q[31], cy_q} - {piy_q[31], piy_q};
        pyp_d   = dyv * ny_q;
        state_d = ST_PRJ_CMP;
      end
      ST_PRJ_CMP: begin
        pr = $signed({pxp_q[50], pxp_q}) + $signed({pyp_q[50], pyp_q});
        if (!got_q || pr < mn_q) begin
          mn_d  = pr;
          bvx_d = cx_q;
          bvy_d = cy_q;
          got_d = 1'b1;
        end
        vj_d    = vj_n;
        state_d = (vj_n == nq) ? ST_EDGE_END : ST_PRJ_RD;
      end
      ST_EDGE_END: begin
        if (!have_q || mn_q > sep_q) begin
          sep_d  = mn_q;
          snx_d  = nx_q;
          sny_d  = ny_q;
          spx_d  = bvx_q;
          spy_d  = bvy_q;
          have_d = 1'b1;
        end
        ei_d    = ei_n;
        state_d = (ei_n == np) ? ST_PASS_END : ST_EDGE_RD0;
      end
      ST_PASS_END: begin
        if (!sep_q[51]) begin
          state_d = ST_EMIT;
        end else if (!pass_q) begin
          sa_d    = sep_q;
          a_nx_d  = snx_q;
          a_ny_d  = sny_q;
          apx_d   = spx_q;
          apy_d   = spy_q;
          pass_d  = 1'b1;
          ei_d    = '0;
          have_d  = 1'b0;
          state_d = ST_EDGE_RD0;
        end else begin
          state_d = ST_FIN_DEP;
        end
      end
      ST_FIN_DEP: begin
        win_d = sa_q > sep_q;
        dneg  = (sa_q > sep_q) ? -sa_q : -sep_q;
        dd    = 36'((dneg + 52'sd32768) >>> 16);
        dep_d = (dd > 36'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : dd[30:0];
        fnx_d = (sa_q > sep_q) ? a_nx_q : -snx_q;
        fny_d = (sa_q > sep_q) ? a_ny_q : -sny_q;
        state_d = ST_FIN_OX;
      end
      ST_FIN_OX: begin
        mprod   = fnx_q * $signed({1'b0, dep_q});
        mrnd    = mprod + 50'sd32768;
        ox_d    = mrnd[49:16];
        state_d = ST_FIN_OY;
      end
      ST_FIN_OY: begin
        mprod   = fny_q * $signed({1'b0, dep_q});
        mrnd    = mprod + 50'sd32768;
        oy_d    = mrnd[49:16];
        state_d = ST_FIN_PT;
      end
      ST_FIN_PT: begin
        base_x = win_q ? apx_q : spx_q;
        base_y = win_q ? apy_q : spy_q;
        if (win_q) begin
          rsx_d = base_x;
          rsy_d = base_y;
          rex_d = sat32(35'(base_x) + 35'(ox_q));
          rey_d = sat32(35'(base_y) + 35'(oy_q));
        end else begin
          rex_d = base_x;
          rey_d = base_y;
          rsx_d = sat32(35'(base_x) - 35'(ox_q));
          rsy_d = sat32(35'(base_y) - 35'(oy_q));
        end
        res_coll_d = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_user_d  = res_coll_q;
          out_data_d  = res_coll_q ?
                        {5'b0, rey_q, rex_q, rsy_q, rsx_q, fny_q, fnx_q, dep_q} : '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      verts_a_q[waddr] <= {q_entry_i.y, q_entry_i.x};
    end
    if (we_b) begin
      verts_b_q[waddr] <= {q_entry_i.y, q_entry_i.x};
    end
    rd_a_q <= verts_a_q[raddr_a];
    rd_b_q <= verts_b_q[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      closed_a_q  <= 1'b0;
      closed_b_q  <= 1'b0;
      pass_q      <= 1'b0;
      ei_q        <= '0;
      vj_q        <= '0;
      dcnt_q      <= '0;
      got_q       <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      res_coll_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      closed_a_q  <= closed_a_d;
      closed_b_q  <= closed_b_d;
      pass_q      <= pass_d;
      ei_q        <= ei_d;
      vj_q        <= vj_d;
      dcnt_q      <= dcnt_d;
      got_q       <= got_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
      res_coll_q  <= res_coll_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;   piy_q <= piy_d;   mx_q <= mx_d;     my_q <= my_d;
    nsx_q <= nsx_d;   nsy_q <= nsy_d;   sq_q <= sq_d;     prod_q <= prod_d;
    sv_q <= sv_d;     sr_q <= sr_d;     sbit_q <= sbit_d;
    rx_q <= rx_d;     ry_q <= ry_d;     dv_q <= dv_d;     qx_q <= qx_d;
    qy_q <= qy_d;     nx_q <= nx_d;     ny_q <= ny_d;     cx_q <= cx_d;
    cy_q <= cy_d;     pxp_q <= pxp_d;   pyp_q <= pyp_d;   mn_q <= mn_d;
    bvx_q <= bvx_d;   bvy_q <= bvy_d;   sep_q <= sep_d;   snx_q <= snx_d;
    sny_q <= sny_d;   spx_q <= spx_d;   spy_q <= spy_d;   sa_q <= sa_d;
    a_nx_q <= a_nx_d; a_ny_q <= a_ny_d; apx_q <= apx_d;   apy_q <= apy_d;
    win_q <= win_d;   dep_q <= dep_d;   fnx_q <= fnx_d;   fny_q <= fny_d;
    ox_q <= ox_d;     oy_q <= oy_d;
    rsx_q <= rsx_d;   rsy_q <= rsy_d;   rex_q <= rex_d;   rey_q <= rey_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

endmodule

`default_nettype wire

@@ hdl/psc_checker.sv @@
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks on the contact result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polygon_sat_contact_defines.svh"

module psc_checker import psc_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                   s_axis_tuser,
  input wire logic                   s_axis_tlast,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tuser
);

  logic [OUT_TDATA_W+1:0] out_word;
  assign out_word = {m_axis_tuser, m_axis_tdata, 1'b0};

  `PSC_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, out_word)
  `PSC_ASSERT_IMPLY(a_clear_no_contact, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
  `PSC_ASSERT_IMPLY(a_contact_normal, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[48:31] != '0) || (m_axis_tdata[66:49] != '0))

endmodule

bind polygon_sat_contact psc_checker u_psc_checker (.*);

`default_nettype wire
